### src/tfcc_pkg.sv
// shared constants for the telemetry frame crc checker
// no dependencies
package tfcc_pkg;

    localparam int unsigned FRAME_LEN = 10;
    localparam int unsigned CRC_LEN   = 8;
    localparam int unsigned STORE_LEN = FRAME_LEN - 1;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_CRC_END = POS_W'(CRC_LEN);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [7:0]       byte_t;
    typedef logic [15:0]      crc_t;

endpackage

### src/tfcc_crc16.sv
// one-byte crc-16/modbus update, reflected polynomial, lsb first
// depends on tfcc_pkg
module tfcc_crc16 (
    input  tfcc_pkg::crc_t  crc_in,
    input  tfcc_pkg::byte_t data_in,
    output tfcc_pkg::crc_t  crc_out
);

    always_comb begin
        tfcc_pkg::crc_t c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ tfcc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### src/telemetry_frame_crc_checker.sv
// telemetry frame crc checker: one byte per word, one result per 10-byte frame
// latency: result valid the cycle after byte 9 is accepted
// throughput: one byte per cycle if s_ready is high; crc update is one registered step
// reset (aresetn low, synchronous): crc to all ones, position and held values to zero,
// output word dropped; stored frame bytes are not cleared
// depends on tfcc_pkg and tfcc_crc16
module telemetry_frame_crc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_ok,
    output logic [15:0] m_computed_crc,
    output logic [7:0]  m_command_byte,
    output logic [7:0]  m_status_byte,
    output logic [15:0] m_temperature,
    output logic [15:0] m_voltage,
    output logic [15:0] m_current
);

    tfcc_pkg::pos_t  pos_reg, pos_next, pos_cur;
    tfcc_pkg::crc_t  crc_reg, crc_next, crc_base, crc_upd;
    tfcc_pkg::byte_t frame_reg [tfcc_pkg::STORE_LEN];
    logic [15:0]     temp_reg, temp_next;
    logic [15:0]     volt_reg, volt_next;
    logic [15:0]     curr_reg, curr_next;

    logic        m_valid_reg, m_valid_next;
    logic        ok_reg;
    logic [15:0] ccrc_reg;
    logic [7:0]  cmd_reg, stat_reg;
    logic [15:0] otemp_reg, ovolt_reg, ocurr_reg;

    logic accept, last_byte, crc_ok;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // frame start or out-of-range position restarts the frame
    always_comb begin
        if (s_frame_start || pos_reg > tfcc_pkg::POS_LAST) begin
            pos_cur  = '0;
            crc_base = tfcc_pkg::CRC_INIT;
        end else begin
            pos_cur  = pos_reg;
            crc_base = crc_reg;
        end
    end

    tfcc_crc16 u_crc (
        .crc_in  (crc_base),
        .data_in (s_data_byte),
        .crc_out (crc_upd)
    );

    assign last_byte = (pos_cur == tfcc_pkg::POS_LAST);
    assign crc_ok    = ({frame_reg[tfcc_pkg::STORE_LEN-1], s_data_byte} == crc_base);

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        temp_next    = temp_reg;
        volt_next    = volt_reg;
        curr_next    = curr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            if (last_byte) begin
                pos_next     = '0;
                crc_next     = tfcc_pkg::CRC_INIT;
                m_valid_next = 1'b1;
                if (crc_ok) begin
                    temp_next = {frame_reg[2], frame_reg[3]};
                    volt_next = {frame_reg[4], frame_reg[5]};
                    curr_next = {frame_reg[6], frame_reg[7]};
                end
            end else begin
                pos_next = pos_cur + tfcc_pkg::pos_t'(1);
                crc_next = (pos_cur < tfcc_pkg::POS_CRC_END) ? crc_upd : crc_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            crc_reg     <= tfcc_pkg::CRC_INIT;
            temp_reg    <= '0;
            volt_reg    <= '0;
            curr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            temp_reg    <= temp_next;
            volt_reg    <= volt_next;
            curr_reg    <= curr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // frame byte store, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < tfcc_pkg::STORE_LEN; i++) begin
            if (accept && pos_cur == tfcc_pkg::pos_t'(i)) begin
                frame_reg[i] <= s_data_byte;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (accept && last_byte) begin
            ok_reg    <= crc_ok;
            ccrc_reg  <= crc_base;
            cmd_reg   <= frame_reg[0];
            stat_reg  <= frame_reg[1];
            otemp_reg <= temp_next;
            ovolt_reg <= volt_next;
            ocurr_reg <= curr_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_ok     = ok_reg;
    assign m_computed_crc = ccrc_reg;
    assign m_command_byte = cmd_reg;
    assign m_status_byte  = stat_reg;
    assign m_temperature  = otemp_reg;
    assign m_voltage      = ovolt_reg;
    assign m_current      = ocurr_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= tfcc_pkg::POS_LAST)
        else $error("frame position out of range");

    a_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_frame_start |=> pos_reg == tfcc_pkg::pos_t'(1))
        else $error("frame start did not restart position");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_frame_start && pos_reg == tfcc_pkg::POS_LAST |=> m_valid_reg)
        else $error("no result after last frame byte");

    a_held_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> otemp_reg == temp_reg && ovolt_reg == volt_reg
                        && ocurr_reg == curr_reg)
        else $error("output word out of step with held values");

endmodule

### tb/telemetry_frame_crc_checker_tb.sv
`timescale 1ns / 1ps
// testbench for telemetry_frame_crc_checker: directed frames from a table, then random frames
// checked against a crc-16/modbus frame predictor; depends on tfcc_pkg and the checker rtl
module telemetry_frame_crc_checker_tb;

    typedef struct {
        logic            ok;
        tfcc_pkg::crc_t  crc;
        tfcc_pkg::byte_t cmd;
        tfcc_pkg::byte_t status;
        logic [15:0]     temp;
        logic [15:0]     volt;
        logic [15:0]     cur;
    } frame_result_t;

    typedef enum int {SRC_RAW, SRC_CRC_HI, SRC_CRC_LO, SRC_CRC_LO_BAD} byte_src_t;

    typedef struct {
        tfcc_pkg::byte_t data;
        logic            start;
        byte_src_t       src;
        int              typed_idx;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam int NO_TYPED = -1;
    localparam int unsigned TARGET_WORDS = 1900;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_ok;
    logic [15:0] m_computed_crc;
    logic [7:0]  m_command_byte;
    logic [7:0]  m_status_byte;
    logic [15:0] m_temperature;
    logic [15:0] m_voltage;
    logic [15:0] m_current;

    // predictor state
    tfcc_pkg::crc_t  crc_acc;
    int unsigned     frame_pos;
    tfcc_pkg::byte_t frame_buf [tfcc_pkg::STORE_LEN];
    logic [15:0]     hold_temp;
    logic [15:0]     hold_volt;
    logic [15:0]     hold_cur;

    frame_result_t expected_frames[$];
    frame_result_t typed_results [2];
    stim_row_t     dir_rows [NUM_ROWS];

    int unsigned failures = 0;
    int unsigned words_sent = 0;
    int unsigned rx_stall = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    telemetry_frame_crc_checker u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_ok     (m_frame_ok),
        .m_computed_crc (m_computed_crc),
        .m_command_byte (m_command_byte),
        .m_status_byte  (m_status_byte),
        .m_temperature  (m_temperature),
        .m_voltage      (m_voltage),
        .m_current      (m_current)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic tfcc_pkg::crc_t crc16_modbus_byte(input tfcc_pkg::crc_t c,
                                                          input tfcc_pkg::byte_t b);
        tfcc_pkg::crc_t v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ tfcc_pkg::CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // advances the frame predictor by one byte; returns 1 when the frame completes
    function automatic bit frame_step(input tfcc_pkg::byte_t b, input logic fs,
                                      output frame_result_t r);
        int unsigned    p;
        tfcc_pkg::crc_t rx_crc;
        r = '{default: '0};
        if (fs || frame_pos >= tfcc_pkg::FRAME_LEN) begin
            frame_pos = 0;
            crc_acc = tfcc_pkg::CRC_INIT;
        end
        p = frame_pos;
        if (p < tfcc_pkg::FRAME_LEN - 1) begin
            frame_buf[p] = b;
            if (p < tfcc_pkg::CRC_LEN)
                crc_acc = crc16_modbus_byte(crc_acc, b);
            frame_pos = p + 1;
            return 1'b0;
        end
        // check value arrives high byte first
        rx_crc = {frame_buf[8], b};
        r.ok = (rx_crc == crc_acc);
        if (r.ok) begin
            hold_temp = {frame_buf[2], frame_buf[3]};
            hold_volt = {frame_buf[4], frame_buf[5]};
            hold_cur  = {frame_buf[6], frame_buf[7]};
        end
        r.crc    = crc_acc;
        r.cmd    = frame_buf[0];
        r.status = frame_buf[1];
        r.temp   = hold_temp;
        r.volt   = hold_volt;
        r.cur    = hold_cur;
        frame_pos = 0;
        crc_acc = tfcc_pkg::CRC_INIT;
        return 1'b1;
    endfunction

    task automatic send_word(input tfcc_pkg::byte_t b, input logic fs, input int typed_idx);
        int unsigned    gap;
        bit             done;
        frame_result_t  r;
        tfcc_pkg::crc_t crc_seen;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        done = frame_step(b, fs, r);
        if (done) begin
            if (typed_idx != NO_TYPED) begin
                crc_seen = r.crc;
                r = typed_results[typed_idx];
                r.crc = crc_seen;
            end
            expected_frames.push_back(r);
        end
    endtask

    task automatic send_random_frame();
        int unsigned    kind;
        int unsigned    len;
        logic           fs;
        tfcc_pkg::crc_t chk;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            // well-formed frame; a flag is needed only if a partial frame is pending
            fs = (frame_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
            send_word(8'($urandom_range(0, 255)), fs, NO_TYPED);
            for (int i = 1; i < tfcc_pkg::CRC_LEN; i++)
                send_word(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
            case ($urandom_range(0, 5))
                0:       chk = 16'($urandom_range(0, 65535));
                1, 2:    chk = crc_acc ^ (16'h0001 << $urandom_range(0, 15));
                default: chk = crc_acc;
            endcase
            send_word(chk[15:8], 1'b0, NO_TYPED);
            send_word(chk[7:0], 1'b0, NO_TYPED);
        end else if (kind < 9) begin
            // truncated frame, dropped by the next frame start
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
                send_word(8'($urandom_range(0, 255)), i == 0, NO_TYPED);
        end else begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, NO_TYPED);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result word with no frame pending");
                failures++;
            end else begin
                e = expected_frames.pop_front();
                check_field("frame_ok", 16'(e.ok), 16'(m_frame_ok));
                check_field("computed_crc", e.crc, m_computed_crc);
                check_field("command_byte", 16'(e.cmd), 16'(m_command_byte));
                check_field("status_byte", 16'(e.status), 16'(m_status_byte));
                check_field("temperature", e.temp, m_temperature);
                check_field("voltage", e.volt, m_voltage);
                check_field("current", e.cur, m_current);
            end
            rx_stall = rx_idle_on ? $urandom_range(0, 6) : 0;
        end else if (rx_stall > 0) begin
            rx_stall--;
        end
        m_ready <= aresetn && (rx_stall == 0);
    end

    initial begin
        tfcc_pkg::byte_t b;
        crc_acc   = tfcc_pkg::CRC_INIT;
        frame_pos = 0;
        hold_temp = '0;
        hold_volt = '0;
        hold_cur  = '0;

        // bad check value right after reset: held values still zero
        typed_results[0] = '{ok: 1'b0, crc: '0, cmd: 8'hFF, status: 8'hFF,
                             temp: 16'h0000, volt: 16'h0000, cur: 16'h0000};
        typed_results[1] = '{ok: 1'b1, crc: '0, cmd: 8'h00, status: 8'h00,
                             temp: 16'hFFFF, volt: 16'h0000, cur: 16'h1234};
        dir_rows = '{
            // all-ones frame with the low check byte inverted
            '{8'hFF, 1'b1, SRC_RAW, NO_TYPED}, '{8'hFF, 1'b0, SRC_RAW, NO_TYPED},
            '{8'hFF, 1'b0, SRC_RAW, NO_TYPED}, '{8'hFF, 1'b0, SRC_RAW, NO_TYPED},
            '{8'hFF, 1'b0, SRC_RAW, NO_TYPED}, '{8'hFF, 1'b0, SRC_RAW, NO_TYPED},
            '{8'hFF, 1'b0, SRC_RAW, NO_TYPED}, '{8'hFF, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h00, 1'b0, SRC_CRC_HI, NO_TYPED}, '{8'h00, 1'b0, SRC_CRC_LO_BAD, 0},
            // partial frame with no start flag, then a restart mid-frame
            '{8'h5A, 1'b0, SRC_RAW, NO_TYPED}, '{8'hA5, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h3C, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h00, 1'b1, SRC_RAW, NO_TYPED}, '{8'h00, 1'b0, SRC_RAW, NO_TYPED},
            '{8'hFF, 1'b0, SRC_RAW, NO_TYPED}, '{8'hFF, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h00, 1'b0, SRC_RAW, NO_TYPED}, '{8'h00, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h12, 1'b0, SRC_RAW, NO_TYPED}, '{8'h34, 1'b0, SRC_RAW, NO_TYPED},
            '{8'h00, 1'b0, SRC_CRC_HI, NO_TYPED}, '{8'h00, 1'b0, SRC_CRC_LO, 1}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            case (dir_rows[i].src)
                SRC_CRC_HI:     b = crc_acc[15:8];
                SRC_CRC_LO:     b = crc_acc[7:0];
                SRC_CRC_LO_BAD: b = ~crc_acc[7:0];
                default:        b = dir_rows[i].data;
            endcase
            send_word(b, dir_rows[i].start, dir_rows[i].typed_idx);
        end

        while (words_sent < TARGET_WORDS) begin
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 7) == 0) begin
                tx_idle_on = $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end
            send_random_frame();
        end
        s_valid <= 1'b0;
        rx_idle_on = 1'b1;

        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
